@@ hdl/multikey_sorted_table_search_macros.svh @@
// assertion macros used by the checker file
`ifndef MULTIKEY_SORTED_TABLE_SEARCH_MACROS_SVH
`define MULTIKEY_SORTED_TABLE_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MKST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MKST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mkst_pkg.sv @@
// types and constants of the sorted multi-key table search
package mkst_pkg;

    localparam int KEY_W    = 32;
    localparam int POS_W    = 10;
    localparam int ROW_W    = 10;
    localparam int CNT_W    = 11;
    localparam int DIMS_W   = 3;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_DIMS = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS  = 1'd1;

    // item functions
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // probe compare outcomes
    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_LT = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    typedef struct packed {
        logic                    func;
        logic [POS_W-1:0]        position;
        logic signed [KEY_W-1:0] key_0;
        logic signed [KEY_W-1:0] key_1;
        logic signed [KEY_W-1:0] key_2;
        logic signed [KEY_W-1:0] key_3;
        logic [ROW_W-1:0]        row_id;
    } req_word_t;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row;
    } rsp_word_t;

endpackage

@@ hdl/mkst_chan_if.sv @@
// valid/ready channel carrying one word per handshake
interface mkst_chan_if #(parameter type word_t = logic);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/multikey_sorted_table_search.sv @@
// sorted multi-key table with binary search over a single table memory
//
// A load word (func 0) writes one table position and gives no
// response; loads to positions at or beyond ROWS are dropped. A search word
// (func 1) runs a binary search over positions 0..row_count-1 and gives one
// response word. Each probe reads the table memory at the midpoint (one read
// port, registered read) and compares the stored keys with the searched
// keys as signed values, dimension 0 first, over num_dims dimensions.
// The first exact match ends the search. The number of probes P is at
// most ceil(log2(count+1)) with count = min(row_count, ROWS), so an empty
// table takes no probe. One item is worked on at a time; a finished
// result sits in the output register so the next word can be taken while
// the response waits. row_count above ROWS counts as ROWS and num_dims
// above KEY_DIMS counts as KEY_DIMS. Table entries are undefined until
// loaded; no clearing pass runs after reset.
module multikey_sorted_table_search #(
    parameter int ROWS     = 1024,
    parameter int KEY_DIMS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mkst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mkst_pkg::CFG_W-1:0]      cfg_data,
    mkst_chan_if.sink                       req,
    mkst_chan_if.source                     rsp
);

    localparam int AW = $clog2(ROWS);
    localparam int CW = $clog2(ROWS + 1);
    localparam int SW = CW + 1;
    localparam int MW = mkst_pkg::ROW_W + KEY_DIMS * mkst_pkg::KEY_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    // configuration registers
    logic [mkst_pkg::CNT_W-1:0]  row_count_reg;
    logic [mkst_pkg::DIMS_W-1:0] num_dims_reg;

    // search control
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] low_reg, low_next;
    logic [CW-1:0] high_excl_reg, high_excl_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic          res_found_reg, res_found_next;
    logic [mkst_pkg::ROW_W-1:0] res_row_reg, res_row_next;
    logic          rsp_valid_reg, rsp_valid_next;
    mkst_pkg::rsp_word_t rsp_word_reg;

    logic signed [mkst_pkg::KEY_W-1:0] key_reg [KEY_DIMS];

    // table memory: row number in the low bits, key columns above
    logic [MW-1:0] table_mem [ROWS];
    logic [MW-1:0] rd_word_reg;
    logic [MW-1:0] wr_word;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    logic signed [mkst_pkg::KEY_W-1:0] key_in [mkst_pkg::MAX_DIMS];
    logic [CW-1:0]                 count;
    logic [mkst_pkg::DIMS_W-1:0]   dims_eff;
    logic [AW-1:0]                 mid_first;
    logic [AW-1:0]                 mid_lower;
    logic [AW-1:0]                 mid_upper;
    logic [CW-1:0]                 mid_plus1;
    logic [1:0]                    cmp;
    logic                          pos_in_range;
    logic                          search_acc;
    logic                          rsp_load;

    assign key_in[0] = req.data.key_0;
    assign key_in[1] = req.data.key_1;
    assign key_in[2] = req.data.key_2;
    assign key_in[3] = req.data.key_3;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_word_reg;

    assign search_acc = req.valid && req.ready && (req.data.func == mkst_pkg::FUNC_SEARCH);

    // clamp configuration to what the hardware holds
    assign count = (32'(row_count_reg) > 32'(ROWS)) ? CW'(ROWS) : CW'(row_count_reg);
    assign dims_eff = (32'(num_dims_reg) > 32'(KEY_DIMS)) ? mkst_pkg::DIMS_W'(KEY_DIMS)
                                                          : num_dims_reg;

    assign pos_in_range = (32'(req.data.position) < 32'(ROWS));
    assign wr_addr      = AW'(32'(req.data.position));

    // both possible next midpoints, ready in parallel with the compare
    assign mid_first = AW'(SW'(count - CW'(1)) >> 1);
    assign mid_lower = AW'((SW'(low_reg) + SW'(mid_reg) - SW'(1)) >> 1);
    assign mid_upper = AW'((SW'(mid_reg) + SW'(high_excl_reg)) >> 1);
    assign mid_plus1 = CW'(mid_reg) + CW'(1);

    always_comb
    begin
        wr_word = '0;
        wr_word[mkst_pkg::ROW_W-1:0] = req.data.row_id;
        for (int d = 0; d < KEY_DIMS; d++)
        begin
            wr_word[mkst_pkg::ROW_W + d * mkst_pkg::KEY_W +: mkst_pkg::KEY_W] = key_in[d];
        end
    end

    // lexicographic signed compare, lowest dimension decides
    always_comb
    begin
        cmp = mkst_pkg::CMP_EQ;
        for (int d = KEY_DIMS - 1; d >= 0; d--)
        begin
            if ((d < int'(dims_eff)) &&
                (rd_word_reg[mkst_pkg::ROW_W + d * mkst_pkg::KEY_W +: mkst_pkg::KEY_W]
                 != key_reg[d]))
            begin
                cmp = ($signed(rd_word_reg[mkst_pkg::ROW_W + d * mkst_pkg::KEY_W +:
                                           mkst_pkg::KEY_W]) < key_reg[d])
                      ? mkst_pkg::CMP_LT : mkst_pkg::CMP_GT;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_excl_next = high_excl_reg;
        mid_next       = mid_reg;
        res_found_next = res_found_reg;
        res_row_next   = res_row_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = mid_reg;
        rsp_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.func == mkst_pkg::FUNC_LOAD)
                    begin
                        wr_en = pos_in_range;
                    end
                    else
                    begin
                        low_next       = '0;
                        high_excl_next = count;
                        res_found_next = 1'b0;
                        res_row_next   = '0;
                        if (count == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = mid_first;
                            mid_next   = mid_first;
                            state_next = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE:
            begin
                case (cmp)
                    mkst_pkg::CMP_EQ:
                    begin
                        res_found_next = 1'b1;
                        res_row_next   = rd_word_reg[mkst_pkg::ROW_W-1:0];
                        state_next     = ST_DONE;
                    end
                    mkst_pkg::CMP_GT:
                    begin
                        // stored row above the key: search the lower half
                        high_excl_next = CW'(mid_reg);
                        if (low_reg < CW'(mid_reg))
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = mid_lower;
                            mid_next = mid_lower;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    mkst_pkg::CMP_LT:
                    begin
                        low_next = mid_plus1;
                        if (mid_plus1 < high_excl_reg)
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = mid_upper;
                            mid_next = mid_upper;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                // hand over once the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            num_dims_reg  <= mkst_pkg::DIMS_W'(1);
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mkst_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data[mkst_pkg::CNT_W-1:0];
                    mkst_pkg::REG_NUM_DIMS:  num_dims_reg  <= cfg_data[mkst_pkg::DIMS_W-1:0];
                    default: ;
                endcase
            end
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // search datapath, no reset needed
    always_ff @(posedge clk)
    begin
        low_reg       <= low_next;
        high_excl_reg <= high_excl_next;
        mid_reg       <= mid_next;
        res_found_reg <= res_found_next;
        res_row_reg   <= res_row_next;
        if (rsp_load)
        begin
            rsp_word_reg.found <= res_found_reg;
            rsp_word_reg.row   <= res_row_reg;
        end
        if (search_acc)
        begin
            for (int d = 0; d < KEY_DIMS; d++)
            begin
                key_reg[d] <= key_in[d];
            end
        end
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= table_mem[rd_addr];
        end
    end

endmodule

@@ hdl/mkst_checker.sv @@
// port-level checks of the table search, bound to the top level
`include "multikey_sorted_table_search_macros.svh"

module mkst_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       req_func,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_found,
    input logic [mkst_pkg::ROW_W-1:0] rsp_row
);

    // a waiting response stays up until taken
    `MKST_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // a search holds the input side until it finishes
    `MKST_ASSERT_NXT(a_search_busy, req_valid && req_ready && (req_func == mkst_pkg::FUNC_SEARCH), !req_ready, "word taken during a search")

    // a miss always reports row zero
    `MKST_ASSERT_IMP(a_miss_row_zero, rsp_valid && !rsp_found, rsp_row == '0, "miss with nonzero row")

    // a load never raises a response
    `MKST_ASSERT_NXT(a_load_silent, req_valid && req_ready && (req_func == mkst_pkg::FUNC_LOAD), !$rose(rsp_valid), "response after a load")

endmodule

bind multikey_sorted_table_search mkst_checker u_mkst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.data.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_found (rsp.data.found),
    .rsp_row   (rsp.data.row)
);
